[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the sprite quad vertex setup block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/svqs_pkg.sv]
// Package for the sprite quad vertex setup block: widths, codes, payload types, tables.
// No dependencies; used by every module of the block.
package svqs_pkg;

  localparam int ANGLE_BITS       = 16;
  localparam int TEXTURE_SIZE_MAX = 4096;
  localparam int TEX_W            = $clog2(TEXTURE_SIZE_MAX + 1);
  localparam int CORDIC_STEPS     = 16;
  localparam int Q_W              = 16;
  localparam int UV_W             = Q_W + 1;
  localparam int XY_W             = 34;
  localparam int Z_W              = 33;
  localparam int CS_W             = 17;
  localparam int PR_W             = 38;
  localparam int POS_W            = 24;
  localparam int CFG_DATA_W       = 13;
  localparam int CFG_INDEX_W      = 2;
  localparam int QUEUE_DEPTH      = 4;
  localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
  localparam logic [CFG_DATA_W-1:0]  TEX_RESET   = CFG_DATA_W'(256);

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TEXTURE_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_TEXTURE_HEIGHT = CFG_INDEX_W'(1);

  // Corner slots in emit order
  localparam logic [2:0] SLOT_BL0 = 3'd0;
  localparam logic [2:0] SLOT_BR  = 3'd1;
  localparam logic [2:0] SLOT_TR0 = 3'd2;
  localparam logic [2:0] SLOT_TR1 = 3'd3;
  localparam logic [2:0] SLOT_TL  = 3'd4;
  localparam logic [2:0] SLOT_BL1 = 3'd5;
  localparam logic [2:0] SLOT_LAST = SLOT_BL1;

  typedef struct packed {
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
    logic [15:0]        sprite_width;
    logic [15:0]        sprite_height;
    logic [15:0]        angle;
    logic [11:0]        tex_left;
    logic [11:0]        tex_bottom;
    logic [12:0]        tex_width;
    logic [12:0]        tex_height;
  } sprite_t;

  typedef struct packed {
    logic signed [23:0] vertex_x;
    logic signed [23:0] vertex_y;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [2:0]         corner_slot;
    logic               last;
  } vertex_t;

  // One lane of the restoring divider
  typedef struct packed {
    logic             sat;
    logic             zero;
    logic [TEX_W-1:0] rem;
    logic [Q_W-1:0]   q;
  } div_lane_t;

  // Front pipeline stage contents
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [1:0]             quad;
    logic signed [23:0]     center_x;
    logic signed [23:0]     center_y;
    logic [15:0]            sprite_width;
    logic [15:0]            sprite_height;
    logic [TEX_W-1:0]       den_u;
    logic [TEX_W-1:0]       den_v;
    div_lane_t              u_left;
    div_lane_t              u_right;
    div_lane_t              v_bottom;
    div_lane_t              v_top;
  } front_stage_t;

  // Classified sprite handed from front to back
  typedef struct packed {
    logic signed [23:0]     center_x;
    logic signed [23:0]     center_y;
    logic [15:0]            sprite_width;
    logic [15:0]            sprite_height;
    logic signed [CS_W-1:0] cos_q15;
    logic signed [CS_W-1:0] sin_q15;
    logic [UV_W-1:0]        u_left;
    logic [UV_W-1:0]        u_right;
    logic [UV_W-1:0]        v_bottom;
    logic [UV_W-1:0]        v_top;
  } setup_t;

  // Arctangent of 2^-i as a 32-bit phase
  function automatic logic [31:0] atan_phase(input logic [3:0] i);
    logic [31:0] r;
    case (i)
      4'd0:    r = 32'd536870912;
      4'd1:    r = 32'd316933406;
      4'd2:    r = 32'd167458907;
      4'd3:    r = 32'd85004756;
      4'd4:    r = 32'd42667331;
      4'd5:    r = 32'd21354465;
      4'd6:    r = 32'd10679838;
      4'd7:    r = 32'd5340245;
      4'd8:    r = 32'd2670163;
      4'd9:    r = 32'd1335087;
      4'd10:   r = 32'd667544;
      4'd11:   r = 32'd333772;
      4'd12:   r = 32'd166886;
      4'd13:   r = 32'd83443;
      4'd14:   r = 32'd41722;
      default: r = 32'd20861;
    endcase
    return r;
  endfunction

  // Clamp a texture size register to 1..TEXTURE_SIZE_MAX
  function automatic logic [TEX_W-1:0] tex_size(input logic [CFG_DATA_W-1:0] r);
    logic [TEX_W-1:0] v;
    if (r == '0) v = TEX_W'(1);
    else if (32'(r) > TEXTURE_SIZE_MAX) v = TEX_W'(TEXTURE_SIZE_MAX);
    else v = TEX_W'(r);
    return v;
  endfunction

endpackage

[rtl/svqs_front.sv]
// Front of the sprite quad vertex setup: accepts sprites, runs a pipelined CORDIC
// for sin/cos and pipelined dividers for u/v. Depends on svqs_pkg.
module svqs_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  svqs_pkg::sprite_t               sprite,
  output logic                            full,
  input  logic [svqs_pkg::CFG_DATA_W-1:0] texture_width,
  input  logic [svqs_pkg::CFG_DATA_W-1:0] texture_height,
  output logic                            q_push,
  output svqs_pkg::setup_t                q_item,
  input  logic                            q_full
);

  localparam int N = svqs_pkg::CORDIC_STEPS;

  logic                   valid [0:N];
  svqs_pkg::front_stage_t st    [0:N];
  svqs_pkg::front_stage_t st_in;
  logic                   adv;

  // One restoring divider step on a lane
  function automatic svqs_pkg::div_lane_t div_step(input svqs_pkg::div_lane_t l,
      input logic [svqs_pkg::TEX_W-1:0] den, input int i);
    svqs_pkg::div_lane_t              o;
    logic [svqs_pkg::Q_W-1:0]         half;
    logic [svqs_pkg::TEX_W:0]         t;
    o    = l;
    half = svqs_pkg::Q_W'(den >> 1);
    t    = {l.rem, half[svqs_pkg::Q_W-1-i]};
    if (t >= {1'b0, den}) begin
      o.rem = svqs_pkg::TEX_W'(t - {1'b0, den});
      o.q   = {l.q[svqs_pkg::Q_W-2:0], 1'b1};
    end else begin
      o.rem = t[svqs_pkg::TEX_W-1:0];
      o.q   = {l.q[svqs_pkg::Q_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // One CORDIC rotation step plus one divider step on each lane
  function automatic svqs_pkg::front_stage_t pipe_step(input svqs_pkg::front_stage_t s,
      input int i);
    svqs_pkg::front_stage_t o;
    logic signed [svqs_pkg::XY_W-1:0] dx;
    logic signed [svqs_pkg::XY_W-1:0] dy;
    logic signed [svqs_pkg::Z_W-1:0]  da;
    o  = s;
    dx = s.y >>> i;
    dy = s.x >>> i;
    da = svqs_pkg::Z_W'(svqs_pkg::atan_phase(4'(i)));
    if (s.z >= 0) begin
      o.x = s.x - dx;
      o.y = s.y + dy;
      o.z = s.z - da;
    end else begin
      o.x = s.x + dx;
      o.y = s.y - dy;
      o.z = s.z + da;
    end
    o.u_left   = div_step(s.u_left,   s.den_u, i);
    o.u_right  = div_step(s.u_right,  s.den_u, i);
    o.v_bottom = div_step(s.v_bottom, s.den_v, i);
    o.v_top    = div_step(s.v_top,    s.den_v, i);
    return o;
  endfunction

  // Lane setup for u: saturate once the edge reaches the width
  function automatic svqs_pkg::div_lane_t u_init(input logic [13:0] e,
      input logic [svqs_pkg::TEX_W-1:0] den);
    svqs_pkg::div_lane_t l;
    l.sat  = (e >= 14'(den));
    l.zero = 1'b0;
    l.rem  = svqs_pkg::TEX_W'(e);
    l.q    = '0;
    return l;
  endfunction

  // Lane setup for v: numerator is height minus row, clipped to 0..height
  function automatic svqs_pkg::div_lane_t v_init(input logic [13:0] r,
      input logic [svqs_pkg::TEX_W-1:0] den);
    svqs_pkg::div_lane_t l;
    logic signed [15:0]  n;
    n      = $signed(16'(den)) - $signed(16'(r));
    l.zero = (n <= 0);
    l.sat  = (n >= $signed(16'(den)));
    l.rem  = svqs_pkg::TEX_W'(n);
    l.q    = '0;
    return l;
  endfunction

  // Round Q30 to Q1.15 and clamp
  function automatic logic signed [svqs_pkg::CS_W-1:0] to_q15(
      input logic signed [svqs_pkg::XY_W-1:0] v);
    logic signed [svqs_pkg::XY_W:0]    t;
    logic signed [svqs_pkg::XY_W-15:0] r;
    logic signed [svqs_pkg::CS_W-1:0]  o;
    t = (svqs_pkg::XY_W+1)'(v) + (svqs_pkg::XY_W+1)'(1 << 14);
    r = t[svqs_pkg::XY_W:15];
    if (r > 32768) o = svqs_pkg::CS_W'(32768);
    else if (r < -32768) o = -svqs_pkg::CS_W'(32768);
    else o = svqs_pkg::CS_W'(r);
    return o;
  endfunction

  // Classify the incoming sprite
  always_comb begin
    logic [31:0] phase;
    logic [13:0] right;
    logic [13:0] top;
    phase = {16'd0, sprite.angle} << (32 - svqs_pkg::ANGLE_BITS);
    right = 14'(sprite.tex_left) + 14'(sprite.tex_width);
    top   = 14'(sprite.tex_bottom) + 14'(sprite.tex_height);
    st_in.x             = svqs_pkg::CORDIC_GAIN;
    st_in.y             = '0;
    st_in.z             = svqs_pkg::Z_W'(phase[29:0]);
    st_in.quad          = phase[31:30];
    st_in.center_x      = sprite.center_x;
    st_in.center_y      = sprite.center_y;
    st_in.sprite_width  = sprite.sprite_width;
    st_in.sprite_height = sprite.sprite_height;
    st_in.den_u         = svqs_pkg::tex_size(texture_width);
    st_in.den_v         = svqs_pkg::tex_size(texture_height);
    st_in.u_left        = u_init(14'(sprite.tex_left), st_in.den_u);
    st_in.u_right       = u_init(right, st_in.den_u);
    st_in.v_bottom      = v_init(14'(sprite.tex_bottom), st_in.den_v);
    st_in.v_top         = v_init(top, st_in.den_v);
  end

  // Advance the whole pipe unless the last stage is blocked by the queue
  assign adv    = !(valid[N] && q_full);
  assign full   = !adv;
  assign q_push = valid[N] && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= N; k++) valid[k] <= 1'b0;
    end else if (adv) begin
      valid[0] <= push;
      for (int k = 0; k < N; k++) valid[k+1] <= valid[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) st[0] <= st_in;
  end

  for (genvar g = 0; g < N; g++) begin : g_stage
    always_ff @(posedge clk) begin
      if (adv) st[g+1] <= pipe_step(st[g], g);
    end
  end

  // Map quadrant and finish u/v
  function automatic logic [svqs_pkg::UV_W-1:0] uv_value(input svqs_pkg::div_lane_t l);
    logic [svqs_pkg::UV_W-1:0] o;
    if (l.zero) o = '0;
    else if (l.sat) o = svqs_pkg::UV_W'(1 << svqs_pkg::Q_W);
    else o = {1'b0, l.q};
    return o;
  endfunction

  always_comb begin
    logic signed [svqs_pkg::CS_W-1:0] c;
    logic signed [svqs_pkg::CS_W-1:0] s;
    c = to_q15(st[N].x);
    s = to_q15(st[N].y);
    case (st[N].quad)
      2'd0: begin q_item.cos_q15 = c;  q_item.sin_q15 = s;  end
      2'd1: begin q_item.cos_q15 = -s; q_item.sin_q15 = c;  end
      2'd2: begin q_item.cos_q15 = -c; q_item.sin_q15 = -s; end
      default: begin q_item.cos_q15 = s; q_item.sin_q15 = -c; end
    endcase
    q_item.center_x      = st[N].center_x;
    q_item.center_y      = st[N].center_y;
    q_item.sprite_width  = st[N].sprite_width;
    q_item.sprite_height = st[N].sprite_height;
    q_item.u_left        = uv_value(st[N].u_left);
    q_item.u_right       = uv_value(st[N].u_right);
    q_item.v_bottom      = uv_value(st[N].v_bottom);
    q_item.v_top         = uv_value(st[N].v_top);
  end

endmodule

[rtl/svqs_queue.sv]
// Short queue between front and back of the sprite quad vertex setup.
// Depends on svqs_pkg.
module svqs_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  svqs_pkg::setup_t wr_item,
  output logic             q_full,
  input  logic             rd,
  output svqs_pkg::setup_t rd_item,
  output logic             q_empty
);

  svqs_pkg::setup_t                mem [0:svqs_pkg::QUEUE_DEPTH-1];
  logic [svqs_pkg::QUEUE_AW-1:0]   wp;
  logic [svqs_pkg::QUEUE_AW-1:0]   rp;
  logic [svqs_pkg::QUEUE_AW:0]     count;

  assign q_full  = (count == (svqs_pkg::QUEUE_AW+1)'(svqs_pkg::QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign rd_item = mem[rp];

  // Move pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      if (wr && !rd) count <= count + 1'b1;
      else if (rd && !wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_item;
  end

endmodule

[rtl/svqs_back.sv]
// Back of the sprite quad vertex setup: rotates corner offsets and emits six vertices
// per sprite through an output register. Depends on svqs_pkg.
module svqs_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  svqs_pkg::setup_t  q_item,
  output logic              q_pop,
  output svqs_pkg::vertex_t vertex,
  output logic              empty,
  input  logic              pop
);

  localparam int SUM_W = svqs_pkg::PR_W + 1;

  logic                              cur_valid;
  logic [2:0]                        slot;
  logic signed [svqs_pkg::PR_W-1:0]  p_xc;
  logic signed [svqs_pkg::PR_W-1:0]  p_ys;
  logic signed [svqs_pkg::PR_W-1:0]  p_yc;
  logic signed [svqs_pkg::PR_W-1:0]  p_xs;
  logic signed [23:0]                cx;
  logic signed [23:0]                cy;
  logic [svqs_pkg::UV_W-1:0]         u_l;
  logic [svqs_pkg::UV_W-1:0]         u_r;
  logic [svqs_pkg::UV_W-1:0]         v_b;
  logic [svqs_pkg::UV_W-1:0]         v_t;
  logic                              out_valid;
  logic                              can_emit;
  logic                              emit;
  logic                              load;
  svqs_pkg::vertex_t                 vtx;

  assign can_emit = !out_valid || pop;
  assign emit     = cur_valid && can_emit;
  assign load     = !q_empty && (!cur_valid || (emit && slot == svqs_pkg::SLOT_LAST));
  assign q_pop    = load;
  assign empty    = !out_valid;

  // Hold the current sprite and step through its slots
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      slot      <= svqs_pkg::SLOT_BL0;
    end else if (load) begin
      cur_valid <= 1'b1;
      slot      <= svqs_pkg::SLOT_BL0;
    end else if (emit) begin
      if (slot == svqs_pkg::SLOT_LAST) cur_valid <= 1'b0;
      slot <= slot + 3'd1;
    end
  end

  // Register the four rotation products on load
  always_ff @(posedge clk) begin
    logic signed [19:0] hx;
    logic signed [19:0] hy;
    if (load) begin
      hx   = $signed({1'b0, q_item.sprite_width, 3'b000});
      hy   = $signed({1'b0, q_item.sprite_height, 3'b000});
      p_xc <= svqs_pkg::PR_W'(hx * q_item.cos_q15);
      p_ys <= svqs_pkg::PR_W'(hy * q_item.sin_q15);
      p_yc <= svqs_pkg::PR_W'(hy * q_item.cos_q15);
      p_xs <= svqs_pkg::PR_W'(hx * q_item.sin_q15);
      cx   <= q_item.center_x;
      cy   <= q_item.center_y;
      u_l  <= q_item.u_left;
      u_r  <= q_item.u_right;
      v_b  <= q_item.v_bottom;
      v_t  <= q_item.v_top;
    end
  end

  function automatic logic signed [23:0] sat_pos(input logic signed [25:0] v);
    logic signed [23:0] o;
    if (v > 26'sd8388607) o = 24'sh7FFFFF;
    else if (v < -26'sd8388608) o = 24'sh800000;
    else o = 24'(v);
    return o;
  endfunction

  // Build the vertex for the current slot
  always_comb begin
    logic                     neg_x;
    logic                     neg_y;
    logic signed [SUM_W-1:0]  sx;
    logic signed [SUM_W-1:0]  sy;
    logic signed [SUM_W-1:0]  rx_sum;
    logic signed [SUM_W-1:0]  ry_sum;
    logic signed [23:0]       rx;
    logic signed [23:0]       ry;
    case (slot)
      svqs_pkg::SLOT_BL0, svqs_pkg::SLOT_BL1: begin neg_x = 1'b1; neg_y = 1'b1; end
      svqs_pkg::SLOT_BR: begin neg_x = 1'b0; neg_y = 1'b1; end
      svqs_pkg::SLOT_TL: begin neg_x = 1'b1; neg_y = 1'b0; end
      default: begin neg_x = 1'b0; neg_y = 1'b0; end
    endcase
    sx     = neg_x ? -SUM_W'(p_xc) : SUM_W'(p_xc);
    sy     = neg_y ? -SUM_W'(p_ys) : SUM_W'(p_ys);
    rx_sum = sx - sy + SUM_W'(1 << 14);
    sx     = neg_y ? -SUM_W'(p_yc) : SUM_W'(p_yc);
    sy     = neg_x ? -SUM_W'(p_xs) : SUM_W'(p_xs);
    ry_sum = sx + sy + SUM_W'(1 << 14);
    rx     = rx_sum[38:15];
    ry     = ry_sum[38:15];
    vtx.vertex_x    = sat_pos(26'(cx) + 26'(rx));
    vtx.vertex_y    = sat_pos(26'(cy) + 26'(ry));
    vtx.tex_u       = neg_x ? u_l : u_r;
    vtx.tex_v       = neg_y ? v_b : v_t;
    vtx.corner_slot = slot;
    vtx.last        = (slot == svqs_pkg::SLOT_LAST);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (can_emit) out_valid <= cur_valid;
  end

  always_ff @(posedge clk) begin
    if (emit) vertex <= vtx;
  end

endmodule

[rtl/sprite_quad_vertex_setup.sv]
// Sprite quad vertex setup: one sprite in, six vertices out (BL, BR, TR, TR, TL, BL).
// A sprite enters every cycle while full is low and passes through the front pipeline
// (an input register, then one CORDIC step and one quotient bit per stage) before it
// reaches a four-entry queue; the back then emits one vertex per cycle while pop keeps
// its output register free, so the six vertices of a sprite leave through the single
// result port one after another, via the back's sprite registers and output register.
// Depends on svqs_pkg, svqs_front, svqs_queue, svqs_back and assert_macros.svh.
`include "assert_macros.svh"

module sprite_quad_vertex_setup (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  svqs_pkg::sprite_t                sprite,
  output logic                             full,
  output svqs_pkg::vertex_t                vertex,
  output logic                             empty,
  input  logic                             pop,
  input  logic                             cfg_write,
  input  logic [svqs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [svqs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [svqs_pkg::CFG_DATA_W-1:0] texture_width;
  logic [svqs_pkg::CFG_DATA_W-1:0] texture_height;
  logic                            q_push;
  logic                            q_full;
  logic                            q_pop;
  logic                            q_empty;
  svqs_pkg::setup_t                q_wr_item;
  svqs_pkg::setup_t                q_rd_item;

  // Configuration registers; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      texture_width  <= svqs_pkg::TEX_RESET;
      texture_height <= svqs_pkg::TEX_RESET;
    end else if (cfg_write) begin
      if (cfg_index == svqs_pkg::REG_TEXTURE_WIDTH) texture_width <= cfg_data;
      if (cfg_index == svqs_pkg::REG_TEXTURE_HEIGHT) texture_height <= cfg_data;
    end
  end

  svqs_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .sprite         (sprite),
    .full           (full),
    .texture_width  (texture_width),
    .texture_height (texture_height),
    .q_push         (q_push),
    .q_item         (q_wr_item),
    .q_full         (q_full)
  );

  svqs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_item (q_wr_item),
    .q_full  (q_full),
    .rd      (q_pop),
    .rd_item (q_rd_item),
    .q_empty (q_empty)
  );

  svqs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_item  (q_rd_item),
    .q_pop   (q_pop),
    .vertex  (vertex),
    .empty   (empty),
    .pop     (pop)
  );

  `ASSERT_CLK_RST(a_last_flag, clk, rst, !empty |-> (vertex.last == (vertex.corner_slot == svqs_pkg::SLOT_LAST)), "last flag disagrees with corner slot")
  `ASSERT_CLK_RST(a_slot_follow, clk, rst, (!empty && pop && !vertex.last) |=> (!empty && vertex.corner_slot == $past(vertex.corner_slot) + 3'd1), "vertex of a sprite missing after pop")
  `ASSERT_CLK_RST(a_queue_guard, clk, rst, !(q_push && q_full) && !(q_pop && q_empty), "queue overrun or underrun")

endmodule

[sim/sprite_quad_vertex_setup_tb.sv]
// Testbench for sprite_quad_vertex_setup: predicts the six vertices of each sprite
// and checks them in order. Depends on svqs_pkg and the block's RTL.
module sprite_quad_vertex_setup_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push;
  svqs_pkg::sprite_t sprite;
  logic full;
  svqs_pkg::vertex_t vertex;
  logic empty;
  logic pop;
  logic cfg_write;
  logic [svqs_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [svqs_pkg::CFG_DATA_W-1:0] cfg_data;

  sprite_quad_vertex_setup u_dut (
    .clk(clk), .rst(rst), .push(push), .sprite(sprite), .full(full),
    .vertex(vertex), .empty(empty), .pop(pop),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic [12:0] tex_w_reg;
  logic [12:0] tex_h_reg;
  svqs_pkg::vertex_t pending_vertices[$];
  int errors = 0;
  int cycles = 0;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int hold_off = 0;

  const longint rot_step[16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861};
  const int corner_sx[6] = '{-1, 1, 1, 1, -1, -1};
  const int corner_sy[6] = '{-1, -1, 1, 1, 1, -1};

  function automatic longint q15_clamp(longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 32768) r = 32768;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic longint pos_clamp(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint eff_size(logic [12:0] r);
    longint v;
    v = r;
    if (v < 1) v = 1;
    if (v > svqs_pkg::TEXTURE_SIZE_MAX) v = svqs_pkg::TEXTURE_SIZE_MAX;
    return v;
  endfunction

  function automatic logic [16:0] unit_ratio(longint num, longint den);
    longint r;
    if (num <= 0) return '0;
    r = (num * 65536 + den / 2) / den;
    if (r > 65536) r = 65536;
    return 17'(r);
  endfunction

  // Expand one sprite into its six vertices
  task automatic predict_quad(input svqs_pkg::sprite_t s);
    logic [31:0] phase;
    longint x, y, z, dx, dy, c, s_q, cs, sn, cx, cy, hx, hy, ox, oy;
    longint left, right, bottom, top, tw, th;
    svqs_pkg::vertex_t v;
    phase = {s.angle[svqs_pkg::ANGLE_BITS-1:0], {(32 - svqs_pkg::ANGLE_BITS){1'b0}}};
    z = phase[29:0];
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= rot_step[i];
      end else begin
        x += dx; y -= dy; z += rot_step[i];
      end
    end
    c = q15_clamp(x);
    s_q = q15_clamp(y);
    case (phase[31:30])
      2'd0: begin cs = c; sn = s_q; end
      2'd1: begin cs = -s_q; sn = c; end
      2'd2: begin cs = -c; sn = -s_q; end
      default: begin cs = s_q; sn = -c; end
    endcase
    cx = s.center_x;
    cy = s.center_y;
    hx = longint'(s.sprite_width) * 8;
    hy = longint'(s.sprite_height) * 8;
    left = s.tex_left;
    bottom = s.tex_bottom;
    right = left + longint'(s.tex_width);
    top = bottom + longint'(s.tex_height);
    tw = eff_size(tex_w_reg);
    th = eff_size(tex_h_reg);
    for (int k = 0; k < 6; k++) begin
      ox = corner_sx[k] * hx;
      oy = corner_sy[k] * hy;
      v.vertex_x = 24'(pos_clamp(cx + ((ox * cs - oy * sn + 16384) >>> 15)));
      v.vertex_y = 24'(pos_clamp(cy + ((oy * cs + ox * sn + 16384) >>> 15)));
      v.tex_u = unit_ratio(corner_sx[k] > 0 ? right : left, tw);
      v.tex_v = unit_ratio(th - (corner_sy[k] > 0 ? top : bottom), th);
      v.corner_slot = 3'(k);
      v.last = (3'(k) == svqs_pkg::SLOT_LAST);
      pending_vertices = {pending_vertices, v};
    end
  endtask

  // Offer one sprite, hold it until accepted
  task automatic send_sprite(input svqs_pkg::sprite_t s);
    if (send_idle && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    push <= 1'b1;
    sprite <= s;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_quad(s);
  endtask

  // Drop push and wait until every vertex has drained
  task automatic drain;
    push <= 1'b0;
    @(posedge clk);
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [svqs_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [12:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == svqs_pkg::REG_TEXTURE_WIDTH) tex_w_reg = val;
    else if (idx == svqs_pkg::REG_TEXTURE_HEIGHT) tex_h_reg = val;
    @(posedge clk);
  endtask

  function automatic svqs_pkg::sprite_t rand_sprite();
    svqs_pkg::sprite_t s;
    s.center_x = 24'($urandom);
    s.center_y = 24'($urandom);
    s.sprite_width = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2047));
    s.sprite_height = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2047));
    s.angle = 16'($urandom);
    s.tex_left = 12'($urandom);
    s.tex_bottom = 12'($urandom);
    s.tex_width = ($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'($urandom_range(0, 512));
    s.tex_height = ($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'($urandom_range(0, 512));
    if ($urandom_range(0, 15) == 0) s.center_x = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
    if ($urandom_range(0, 15) == 0) s.center_y = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
    return s;
  endfunction

  function automatic svqs_pkg::sprite_t make_sprite(logic [23:0] cx, logic [23:0] cy,
                                          logic [15:0] w,
                                          logic [15:0] h, logic [15:0] a, logic [11:0] l,
                                          logic [11:0] b, logic [12:0] tw, logic [12:0] th);
    svqs_pkg::sprite_t s;
    s.center_x = cx; s.center_y = cy; s.sprite_width = w; s.sprite_height = h;
    s.angle = a; s.tex_left = l; s.tex_bottom = b; s.tex_width = tw; s.tex_height = th;
    return s;
  endfunction

  // Extremes, quadrant angles, saturation and out-of-texture rectangles
  task automatic test_directed;
    send_sprite(make_sprite(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_sprite(make_sprite(24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            12'hFFF, 12'hFFF, 13'd4096, 13'd4096));
    send_sprite(make_sprite(24'h800000, 24'h800000, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0));
    send_sprite(make_sprite(100, 200, 160, 320, 16'd16384, 16, 32, 64, 64));
    send_sprite(make_sprite(-500, 700, 160, 320, 16'd32768, 0, 0, 256, 256));
    send_sprite(make_sprite(900, -300, 160, 320, 16'd49152, 128, 128, 128, 128));
    send_sprite(make_sprite(0, 0, 1000, 1000, 16'd8192, 0, 0, 1, 1));
    send_sprite(make_sprite(0, 0, 1000, 1000, 16'd65535, 255, 255, 1, 1));
    send_sprite(make_sprite(24'h7FFF00, 24'h800100, 16'hFFFF, 0, 16'd24576, 300, 300,
                            13'h1FFF, 13'h1FFF));
    send_sprite(make_sprite(0, 0, 0, 16'hFFFF, 16'd40000, 12'hAAA, 12'h555, 13'h0AAA, 13'h1555));
    send_sprite(make_sprite(24'h555555, 24'hAAAAAA, 16'h5555, 16'hAAAA, 16'hAAAA,
                            12'h555, 12'hAAA, 13'h1555, 13'h0AAA));
    drain();
  endtask

  // Zero, oversized and unknown-index register writes
  task automatic test_config_sweep;
    logic [12:0] vals[6] = '{13'd0, 13'd1, 13'd4096, 13'h1FFF, 13'd300, 13'd4097};
    foreach (vals[i]) begin
      write_reg(svqs_pkg::REG_TEXTURE_WIDTH, vals[i]);
      write_reg(svqs_pkg::REG_TEXTURE_HEIGHT, vals[5 - i]);
      write_reg(2'd2, 13'($urandom));
      write_reg(2'd3, 13'($urandom));
      repeat (6) send_sprite(rand_sprite());
      send_sprite(make_sprite(0, 0, 16, 16, 0, 12'hFFF, 0, 13'd4096, 13'd4096));
      drain();
    end
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 59) begin
        drain();
        write_reg(svqs_pkg::REG_TEXTURE_WIDTH, 13'($urandom_range(1, 4096)));
        write_reg(svqs_pkg::REG_TEXTURE_HEIGHT, 13'($urandom_range(1, 4096)));
      end
      send_sprite(rand_sprite());
    end
    drain();
  endtask

  // Hold off the reader long enough that full must rise
  task automatic test_backpressure;
    bit saved;
    saved = send_idle;
    send_idle = 1'b0;
    hold_off = 400;
    repeat (30) send_sprite(rand_sprite());
    send_idle = saved;
    drain();
  endtask

  // Check each popped vertex against the oldest prediction
  always @(posedge clk) begin
    svqs_pkg::vertex_t exp_v;
    if (!rst) begin
      if (pop && !empty) begin
        if (pending_vertices.size() == 0) begin
          $error("vertex with nothing expected");
          errors++;
        end else begin
          exp_v = pending_vertices.pop_front();
          if (vertex.vertex_x !== exp_v.vertex_x) begin
            $error("vertex_x expected %0d actual %0d", exp_v.vertex_x, vertex.vertex_x); errors++;
          end
          if (vertex.vertex_y !== exp_v.vertex_y) begin
            $error("vertex_y expected %0d actual %0d", exp_v.vertex_y, vertex.vertex_y); errors++;
          end
          if (vertex.tex_u !== exp_v.tex_u) begin
            $error("tex_u expected %0d actual %0d", exp_v.tex_u, vertex.tex_u); errors++;
          end
          if (vertex.tex_v !== exp_v.tex_v) begin
            $error("tex_v expected %0d actual %0d", exp_v.tex_v, vertex.tex_v); errors++;
          end
          if (vertex.corner_slot !== exp_v.corner_slot) begin
            $error("corner_slot expected %0d actual %0d", exp_v.corner_slot, vertex.corner_slot);
            errors++;
          end
          if (vertex.last !== exp_v.last) begin
            $error("last expected %0d actual %0d", exp_v.last, vertex.last); errors++;
          end
        end
      end
    end
  end

  // Reader stalls: long hold-off first, then random bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      pop <= 1'b0;
    end else if (recv_idle && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 15);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Give up on a hang
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sprite_quad_vertex_setup_tb failed");
      $finish;
    end
  end

  initial begin
    push <= 1'b0;
    sprite <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    tex_w_reg = 13'd256;
    tex_h_reg = 13'd256;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random(120);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    test_random(70);
    if (errors == 0) begin
      $display("sprite_quad_vertex_setup_tb passed");
    end else begin
      $display("sprite_quad_vertex_setup_tb failed");
    end
    $finish;
  end

endmodule
